FILE: rtl/lcrs_pkg.sv
// Shared constants and types of the load cell reading scaler.
package lcrs_pkg;

  localparam int RAW_BITS   = 24;
  localparam int WORD_W     = 24;
  localparam int TIME_W     = 32;
  localparam int MASS_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int MIN_IVL_W  = 16;
  localparam int MARGIN_W   = 23;
  localparam int NUM_W      = 24;
  localparam int DEN_W      = 16;
  localparam int MASS_SCALE = 1000;

  // Serial multiply and divide datapath widths.
  localparam int MAG_W  = WORD_W;
  localparam int MULT_W = DEN_W + 10;
  localparam int PROD_W = MAG_W + MULT_W;
  localparam int DIV_W  = NUM_W;
  localparam int QUOT_W = MASS_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_INTERVAL = 3'd0,
    CFG_LIMIT_MARGIN = 3'd1,
    CFG_CAL_ENABLED  = 3'd2,
    CFG_COUNTS_NUM   = 3'd3,
    CFG_COUNTS_DEN   = 3'd4,
    CFG_TARE_OFFSET  = 3'd5,
    CFG_TARE_VALID   = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic              start;
    logic [MAG_W-1:0]  mag;
    logic [MULT_W-1:0] mult;
    logic [DIV_W-1:0]  divisor;
  } md_req_t;

  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [QUOT_W-1:0] quot;
  } md_res_t;

endpackage

FILE: rtl/load_cell_reading_scaler.sv
// Top level of the load cell reading scaler: poll gating, tare, scaling, result register.
//
// Each input word is one poll of the converter: a millisecond time, the
// ready level and the 24-bit raw word. Every accepted input word yields
// exactly one output word on the valid/ready result channel. A poll that is
// not taken (converter not ready, or the minimum interval not yet elapsed)
// yields a word with every field zero.
//
// A taken reading with tare and scale factor provisioned runs through a
// serial unit: a shift-and-add multiply by 1000 times the denominator, then
// a restoring divide by the numerator. No new input word is taken while an
// item is in flight; the input reopens once a word moves into the output
// register, so the next poll may enter while that word still waits.
//
// Configuration writes (cfg_wr_en, one register per cycle) belong in idle
// time; unknown indexes are ignored. Synchronous reset clears the state, the
// settings, the last read time and the output valid. If the receiver stalls,
// the output word holds and the block stops taking input after one more.
module load_cell_reading_scaler (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [lcrs_pkg::TIME_W-1:0]        in_now_ms,
  input  logic                               in_data_ready,
  input  logic [lcrs_pkg::WORD_W-1:0]        in_raw_word,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_read_taken,
  output logic signed [lcrs_pkg::WORD_W-1:0] out_raw_value,
  output logic                               out_near_limit,
  output logic                               out_mass_valid,
  output logic signed [lcrs_pkg::MASS_W-1:0] out_mass_mg,
  input  logic                               cfg_wr_en,
  input  logic [lcrs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lcrs_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import lcrs_pkg::*;

  localparam int SHIFT = WORD_W - RAW_BITS;
  localparam logic signed [WORD_W:0] FULL_MAX = (WORD_W + 1)'((1 << (RAW_BITS - 1)) - 1);
  localparam logic signed [WORD_W:0] FULL_MIN = -FULL_MAX - 1;
  localparam logic [QUOT_W-1:0] NEG_LIMIT = {1'b1, {(QUOT_W - 1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  // Configuration registers.
  logic [MIN_IVL_W-1:0] min_ivl_r;
  logic [MARGIN_W-1:0]  margin_r;
  logic                 cal_en_r;
  logic [NUM_W-1:0]     num_r;
  logic [DEN_W-1:0]     den_r;
  logic [WORD_W-1:0]    tare_r;
  logic                 tare_valid_r;

  state_t               state_r, state_nxt;
  logic [TIME_W-1:0]    last_r, last_nxt;

  // Result of the item in flight.
  logic                     taken_r, taken_nxt;
  logic [WORD_W-1:0]        raw_r, raw_nxt;
  logic                     near_r, near_nxt;
  logic                     neg_r, neg_nxt;
  logic                     mvalid_r, mvalid_nxt;
  logic [MASS_W-1:0]        mass_r, mass_nxt;

  // Output register.
  logic                     out_valid_r, out_valid_nxt;
  logic                     o_taken_r, o_taken_nxt;
  logic [WORD_W-1:0]        o_raw_r, o_raw_nxt;
  logic                     o_near_r, o_near_nxt;
  logic                     o_mvalid_r, o_mvalid_nxt;
  logic [MASS_W-1:0]        o_mass_r, o_mass_nxt;

  logic                     accept;
  logic [WORD_W-1:0]        raw_shl;
  logic signed [WORD_W-1:0] raw_sx;
  logic signed [WORD_W:0]   raw_ext;
  logic signed [WORD_W:0]   lo_lim;
  logic signed [WORD_W:0]   hi_lim;
  logic signed [WORD_W:0]   counts;
  logic [WORD_W:0]          cmag;
  logic [TIME_W-1:0]        elapsed;
  logic                     take;
  logic                     calc_ok;
  logic                     q_fits;
  logic                     out_free;
  md_req_t                  md_req;
  md_res_t                  md_res;

  // Only the low RAW_BITS bits of the raw word carry the reading.
  assign raw_shl = in_raw_word << SHIFT;
  assign raw_sx  = $signed(raw_shl) >>> SHIFT;
  assign raw_ext = {raw_sx[WORD_W-1], raw_sx};

  assign lo_lim = FULL_MIN + $signed({2'b00, margin_r});
  assign hi_lim = FULL_MAX - $signed({2'b00, margin_r});

  assign counts = raw_ext - $signed({tare_r[WORD_W-1], tare_r});
  assign cmag   = counts[WORD_W] ? (WORD_W + 1)'(0) - counts : counts;

  // A stored time of zero means no reading has been taken yet.
  assign elapsed = in_now_ms - last_r;
  assign take    = in_data_ready &&
                   ((last_r == '0) || (elapsed >= TIME_W'(min_ivl_r)));
  assign calc_ok = tare_valid_r && cal_en_r && (num_r != '0) && (den_r != '0);

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign md_req.start   = accept && take && calc_ok;
  assign md_req.mag     = cmag[MAG_W-1:0];
  assign md_req.mult    = MULT_W'(den_r) * MULT_W'(MASS_SCALE);
  assign md_req.divisor = num_r;

  lcrs_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .res   (md_res)
  );

  // The quotient magnitude may reach 2^31 only for a negative mass.
  assign q_fits = !md_res.ovf && (neg_r ? (md_res.quot <= NEG_LIMIT) : !md_res.quot[QUOT_W-1]);

  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    taken_nxt     = taken_r;
    raw_nxt       = raw_r;
    near_nxt      = near_r;
    neg_nxt       = neg_r;
    mvalid_nxt    = mvalid_r;
    mass_nxt      = mass_r;
    out_valid_nxt = out_valid_r && !out_ready;
    o_taken_nxt   = o_taken_r;
    o_raw_nxt     = o_raw_r;
    o_near_nxt    = o_near_r;
    o_mvalid_nxt  = o_mvalid_r;
    o_mass_nxt    = o_mass_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          taken_nxt  = 1'b0;
          raw_nxt    = '0;
          near_nxt   = 1'b0;
          neg_nxt    = 1'b0;
          mvalid_nxt = 1'b0;
          mass_nxt   = '0;
          state_nxt  = ST_FIN;
          if (take) begin
            last_nxt  = in_now_ms;
            taken_nxt = 1'b1;
            raw_nxt   = raw_sx;
            near_nxt  = (raw_ext <= lo_lim) || (raw_ext >= hi_lim);
            neg_nxt   = counts[WORD_W];
            if (calc_ok) begin
              state_nxt = ST_CALC;
            end
          end
        end
      end
      ST_CALC: begin
        if (md_res.done) begin
          mvalid_nxt = q_fits;
          if (!q_fits) begin
            mass_nxt = '0;
          end else if (neg_r) begin
            mass_nxt = MASS_W'(0) - md_res.quot;
          end else begin
            mass_nxt = md_res.quot;
          end
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_taken_nxt   = taken_r;
          o_raw_nxt     = raw_r;
          o_near_nxt    = near_r;
          o_mvalid_nxt  = mvalid_r;
          o_mass_nxt    = mass_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      last_r       <= '0;
      out_valid_r  <= 1'b0;
      min_ivl_r    <= '0;
      margin_r     <= '0;
      cal_en_r     <= 1'b0;
      num_r        <= '0;
      den_r        <= '0;
      tare_r       <= '0;
      tare_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_MIN_INTERVAL: min_ivl_r    <= cfg_data[MIN_IVL_W-1:0];
          CFG_LIMIT_MARGIN: margin_r     <= cfg_data[MARGIN_W-1:0];
          CFG_CAL_ENABLED:  cal_en_r     <= cfg_data[0];
          CFG_COUNTS_NUM:   num_r        <= cfg_data[NUM_W-1:0];
          CFG_COUNTS_DEN:   den_r        <= cfg_data[DEN_W-1:0];
          CFG_TARE_OFFSET:  tare_r       <= cfg_data[WORD_W-1:0];
          CFG_TARE_VALID:   tare_valid_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    taken_r    <= taken_nxt;
    raw_r      <= raw_nxt;
    near_r     <= near_nxt;
    neg_r      <= neg_nxt;
    mvalid_r   <= mvalid_nxt;
    mass_r     <= mass_nxt;
    o_taken_r  <= o_taken_nxt;
    o_raw_r    <= o_raw_nxt;
    o_near_r   <= o_near_nxt;
    o_mvalid_r <= o_mvalid_nxt;
    o_mass_r   <= o_mass_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_read_taken = o_taken_r;
  assign out_raw_value  = o_raw_r;
  assign out_near_limit = o_near_r;
  assign out_mass_valid = o_mvalid_r;
  assign out_mass_mg    = o_mass_r;

endmodule

FILE: rtl/lcrs_muldiv.sv
// Bit-serial unsigned multiply followed by a restoring divide, one bit per cycle.
module lcrs_muldiv (
  input  logic              clk,
  input  logic              rst_n,
  input  lcrs_pkg::md_req_t req,
  output lcrs_pkg::md_res_t res
);
  import lcrs_pkg::*;

  localparam int CNT_W = $clog2(PROD_W + 1);

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_MUL  = 3'b010,
    MD_DIV  = 3'b100
  } md_state_t;

  md_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [MULT_W-1:0] mult_r, mult_nxt;
  logic [DIV_W-1:0]  div_r, div_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [QUOT_W-1:0] q_r, q_nxt;
  logic              ovf_r, ovf_nxt;
  logic              done_r, done_nxt;

  logic [MULT_W:0]   sum;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              ge;

  assign sum   = {1'b0, prod_r[PROD_W-1:MAG_W]} + {1'b0, (prod_r[0] ? mult_r : '0)};
  assign trial = {rem_r, prod_r[PROD_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign ge    = trial >= {1'b0, div_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    prod_nxt  = prod_r;
    mult_nxt  = mult_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    ovf_nxt   = ovf_r;
    done_nxt  = 1'b0;
    case (state_r)
      MD_IDLE: begin
        if (req.start) begin
          prod_nxt  = {{MULT_W{1'b0}}, req.mag};
          mult_nxt  = req.mult;
          div_nxt   = req.divisor;
          cnt_nxt   = '0;
          state_nxt = MD_MUL;
        end
      end
      MD_MUL: begin
        prod_nxt = {sum, prod_r[MAG_W-1:1]};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MAG_W - 1)) begin
          cnt_nxt   = '0;
          rem_nxt   = '0;
          q_nxt     = '0;
          ovf_nxt   = 1'b0;
          state_nxt = MD_DIV;
        end
      end
      MD_DIV: begin
        prod_nxt = prod_r << 1;
        rem_nxt  = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        q_nxt    = {q_r[QUOT_W-2:0], ge};
        // Any quotient bit pushed past the top marks the result as too large.
        ovf_nxt  = ovf_r | q_r[QUOT_W-1];
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(PROD_W - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = MD_IDLE;
        end
      end
      default: state_nxt = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    mult_r <= mult_nxt;
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    ovf_r  <= ovf_nxt;
  end

  assign res.done = done_r;
  assign res.ovf  = ovf_r;
  assign res.quot = q_r;

endmodule

FILE: rtl/lcrs_checker.sv
// Port-level checks of the load cell reading scaler, bound to the top level.
module lcrs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_read_taken,
  input logic [23:0] out_raw_value,
  input logic        out_near_limit,
  input logic        out_mass_valid,
  input logic [31:0] out_mass_mg
);

  // A stalled output word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mass_mg) && $stable(out_raw_value))
    else $error("output word changed while stalled");

  // A poll that was not taken reports nothing else.
  a_not_taken_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_read_taken |->
      out_raw_value == 24'd0 && !out_near_limit && !out_mass_valid)
    else $error("untaken poll carries data");

  // An invalid mass reads as zero.
  a_mass_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_mass_valid |-> out_mass_mg == 32'd0)
    else $error("invalid mass is not zero");

  // No output word appears in the cycle right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // Input is refused in the cycle after an input word is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second input word taken while busy");

endmodule

bind load_cell_reading_scaler lcrs_checker u_lcrs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_read_taken (out_read_taken),
  .out_raw_value  (out_raw_value),
  .out_near_limit (out_near_limit),
  .out_mass_valid (out_mass_valid),
  .out_mass_mg    (out_mass_mg)
);

FILE: verif/lcrs_reading_checker.sv
// Checker for the load cell reading scaler: predicts each result word and compares it.
`timescale 1ns / 1ps
module lcrs_reading_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic [lcrs_pkg::TIME_W-1:0]          in_now_ms,
  input  logic                                 in_data_ready,
  input  logic [lcrs_pkg::WORD_W-1:0]          in_raw_word,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic                                 out_read_taken,
  input  logic signed [lcrs_pkg::WORD_W-1:0]   out_raw_value,
  input  logic                                 out_near_limit,
  input  logic                                 out_mass_valid,
  input  logic signed [lcrs_pkg::MASS_W-1:0]   out_mass_mg,
  input  logic                                 cfg_wr_en,
  input  logic [lcrs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lcrs_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                   mismatches,
  output int                                   backlog,
  output int                                   compared,
  output int                                   reads_taken,
  output int                                   masses_valid
);
  import lcrs_pkg::*;

  localparam int     MAX_PRINTS = 100;
  localparam longint FULL_MAX   = (longint'(1) << (RAW_BITS - 1)) - 1;
  localparam longint FULL_MIN   = -FULL_MAX - 1;
  localparam longint MASS_MAX   = (longint'(1) << (MASS_W - 1)) - 1;
  localparam longint MASS_MIN   = -MASS_MAX - 1;

  typedef struct {
    logic                      read_taken;
    logic signed [WORD_W-1:0]  raw_value;
    logic                      near_limit;
    logic                      mass_valid;
    logic signed [MASS_W-1:0]  mass_mg;
  } reading_t;

  // Local copy of the configuration registers and of the last read time.
  logic [MIN_IVL_W-1:0]     min_interval;
  logic [MARGIN_W-1:0]      margin;
  logic                     cal_enabled;
  logic [NUM_W-1:0]         counts_num;
  logic [DEN_W-1:0]         counts_den;
  logic signed [WORD_W-1:0] tare;
  logic                     tare_set;
  logic [TIME_W-1:0]        last_read_ms;

  reading_t expected_readings[$];

  task automatic report_mismatch(string msg);
    if (mismatches < MAX_PRINTS) $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic signed [63:0] got, logic signed [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // Gates the poll, then tares and scales the reading; updates the last read time.
  function automatic reading_t predict_reading(logic [TIME_W-1:0] now, logic rdy,
                                               logic [WORD_W-1:0] word);
    reading_t          r;
    logic [TIME_W-1:0] elapsed;
    longint            raw_l;
    longint            margin_l;
    longint            counts;
    longint            prod;
    longint            quot;
    r = '{read_taken: 1'b0, raw_value: '0, near_limit: 1'b0, mass_valid: 1'b0, mass_mg: '0};
    elapsed = now - last_read_ms;
    if (!rdy || (last_read_ms != '0 && elapsed < TIME_W'(min_interval))) return r;
    last_read_ms = now;
    raw_l = signed'(word[RAW_BITS-1:0]);
    margin_l = margin;
    r.read_taken = 1'b1;
    r.raw_value = raw_l[WORD_W-1:0];
    r.near_limit = (raw_l <= FULL_MIN + margin_l) || (raw_l >= FULL_MAX - margin_l);
    if (tare_set && cal_enabled && counts_num != '0 && counts_den != '0) begin
      counts = raw_l - longint'(tare);
      prod = counts * MASS_SCALE * longint'(counts_den);
      // Signed division truncates toward zero, as the mass must.
      quot = prod / longint'(counts_num);
      if (quot >= MASS_MIN && quot <= MASS_MAX) begin
        r.mass_valid = 1'b1;
        r.mass_mg = quot[MASS_W-1:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    reading_t want;
    if (!rst_n) begin
      min_interval = '0;
      margin = '0;
      cal_enabled = 1'b0;
      counts_num = '0;
      counts_den = '0;
      tare = '0;
      tare_set = 1'b0;
      last_read_ms = '0;
      expected_readings.delete();
      mismatches = 0;
      compared = 0;
      reads_taken = 0;
      masses_valid = 0;
    end else begin
      if (out_valid && out_ready) begin
        compared++;
        if (expected_readings.size() == 0) begin
          report_mismatch("result word with no poll outstanding");
        end else begin
          want = expected_readings.pop_front();
          check_field("read_taken", out_read_taken, want.read_taken);
          check_field("raw_value", out_raw_value, want.raw_value);
          check_field("near_limit", out_near_limit, want.near_limit);
          check_field("mass_valid", out_mass_valid, want.mass_valid);
          check_field("mass_mg", out_mass_mg, want.mass_mg);
        end
      end
      if (in_valid && in_ready) begin
        want = predict_reading(in_now_ms, in_data_ready, in_raw_word);
        if (want.read_taken) reads_taken++;
        if (want.mass_valid) masses_valid++;
        expected_readings.push_back(want);
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_MIN_INTERVAL: min_interval = cfg_data[MIN_IVL_W-1:0];
          CFG_LIMIT_MARGIN: margin = cfg_data[MARGIN_W-1:0];
          CFG_CAL_ENABLED:  cal_enabled = cfg_data[0];
          CFG_COUNTS_NUM:   counts_num = cfg_data[NUM_W-1:0];
          CFG_COUNTS_DEN:   counts_den = cfg_data[DEN_W-1:0];
          CFG_TARE_OFFSET:  tare = signed'(cfg_data[WORD_W-1:0]);
          CFG_TARE_VALID:   tare_set = cfg_data[0];
          default: ;
        endcase
      end
    end
    backlog = expected_readings.size();
  end

endmodule

FILE: verif/tb.sv
// Testbench top of the load cell reading scaler: poll stimulus, register setups and verdict.
`timescale 1ns / 1ps
module tb;
  import lcrs_pkg::*;

  // Clock, reset and run length.
  localparam int HALF_NS      = 4;
  localparam int RESET_CYCLES = 11;
  localparam int LIMIT_CYCLES = 1_200_000;

  // Traffic shape: idle odds per cycle, how long the receiver holds off,
  // and how long to keep watching after the last expected word.
  localparam int IDLE_PCT     = 22;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASES       = 8;
  localparam int PHASE_POLLS  = 210;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [TIME_W-1:0]         in_now_ms = '0;
  logic                      in_data_ready = 1'b0;
  logic [WORD_W-1:0]         in_raw_word = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      out_read_taken;
  logic signed [WORD_W-1:0]  out_raw_value;
  logic                      out_near_limit;
  logic                      out_mass_valid;
  logic signed [MASS_W-1:0]  out_mass_mg;
  logic                      cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  int mismatches;
  int backlog;
  int compared;
  int reads_taken;
  int masses_valid;

  // Stimulus bookkeeping. The millisecond clock only moves forward for
  // well-formed polls, so the interval gate sees realistic spacing.
  bit                calm = 1'b0;
  bit                hold_rx = 1'b0;
  logic [TIME_W-1:0] ms_clock = '0;
  int unsigned       cur_interval = 0;
  int                polls_sent = 0;
  int                setups = 0;

  always begin
    #HALF_NS clk = 1'b1;
    #HALF_NS clk = 1'b0;
  end

  load_cell_reading_scaler i_dut (.*);

  lcrs_reading_checker i_checker (.*);

  // Receiver side. It stalls at random unless the run is in its calm
  // stretch. When asked, it holds off for a long, fixed number of cycles so
  // that the block fills up and has to push back on its input.
  always @(negedge clk) begin
    if (hold_rx) begin
      out_ready = 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_rx = 1'b0;
    end
    out_ready = calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Hard stop in case the handshake hangs somewhere.
  initial begin
    #(2 * HALF_NS * LIMIT_CYCLES);
    $display("Run timed out with %0d result words still outstanding.", backlog);
    $display("load_cell_reading_scaler: mismatch");
    $finish;
  end

  // Offers one poll word and returns at the edge where it was taken. The
  // valid stays high from one word to the next unless an idle cycle falls
  // in between, so back-to-back words are exercised as well.
  task automatic offer_poll(logic [TIME_W-1:0] now, logic rdy, logic [WORD_W-1:0] word);
    @(negedge clk);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    in_valid = 1'b1;
    in_now_ms = now;
    in_data_ready = rdy;
    in_raw_word = word;
    do @(posedge clk); while (!in_ready);
    polls_sent++;
  endtask

  // Stops offering and waits until every outstanding result word is back.
  // Every poll yields a word, so an empty backlog means the block is idle.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    wait (backlog == 0);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Half the time, fills the bits above a register's width with junk; the
  // block has to drop them.
  function automatic logic [CFG_DATA_W-1:0] pad(int unsigned value, int width);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom_range(1) ? (CFG_DATA_W'($urandom()) << width) : '0;
    return CFG_DATA_W'(value) | junk;
  endfunction

  task automatic load_setup(int unsigned ivl, int unsigned margin, int unsigned cal,
                            int unsigned num, int unsigned den, int unsigned tare,
                            int unsigned tare_ok);
    write_reg(CFG_MIN_INTERVAL, pad(ivl, MIN_IVL_W));
    write_reg(CFG_LIMIT_MARGIN, pad(margin, MARGIN_W));
    write_reg(CFG_CAL_ENABLED, pad(cal, 1));
    write_reg(CFG_COUNTS_NUM, pad(num, NUM_W));
    write_reg(CFG_COUNTS_DEN, pad(den, DEN_W));
    write_reg(CFG_TARE_OFFSET, CFG_DATA_W'(tare));
    write_reg(CFG_TARE_VALID, pad(tare_ok, 1));
    if ($urandom_range(1)) write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom()));
    cur_interval = ivl;
    setups++;
  endtask

  // A plausible scale: the numerator is the denominator times a counts per
  // gram figure. Now and then that figure is tiny, which drives the mass
  // out of 32-bit range. Any of the gates may be switched off by the caller.
  task automatic realistic_setup(bit cal, bit num_on, bit den_on, bit tare_on);
    int unsigned ivl;
    int unsigned margin;
    int unsigned den;
    int unsigned k;
    ivl = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 200);
    case ($urandom_range(3))
      0: margin = 0;
      1: margin = $urandom_range(1, 1000);
      2: margin = $urandom_range(0, 8388607);
      default: margin = 8388607 - $urandom_range(0, 50);
    endcase
    den = $urandom_range(1, 4000);
    k = ($urandom_range(4) == 0) ? $urandom_range(1, 7) : $urandom_range(8, 4000);
    load_setup(ivl, margin, cal, num_on ? den * k : 0, den_on ? den : 0, $urandom(), tare_on);
  endtask

  // Raw words cluster at both full-scale limits and around zero, where the
  // saturation flag and the sign handling turn over; the rest is uniform.
  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(9))
      0, 1: return 24'h7F_FFFF - WORD_W'($urandom_range(300));
      2, 3: return 24'h80_0000 + WORD_W'($urandom_range(300));
      4: return WORD_W'($urandom_range(2000)) - 24'd1000;
      default: return WORD_W'($urandom());
    endcase
  endfunction

  // Most polls follow the millisecond clock with steps on both sides of the
  // minimum interval and the converter mostly ready. The rest are noise:
  // any time at all and a random ready level.
  task automatic offer_random_poll();
    logic [TIME_W-1:0] now;
    logic              rdy;
    if ($urandom_range(99) < 85) begin
      // Once in a while jump just short of the wrap so the clock crosses
      // zero and sometimes lands on it exactly.
      if ($urandom_range(99) == 0) ms_clock = '0 - TIME_W'($urandom_range(0, 2 * cur_interval + 3));
      ms_clock += TIME_W'($urandom_range(0, 2 * cur_interval + 3));
      now = ms_clock;
      rdy = ($urandom_range(9) != 0);
    end else begin
      now = $urandom();
      rdy = 1'($urandom_range(1));
    end
    offer_poll(now, rdy, random_word());
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset values: no interval, no margin, no scale. Every ready poll is
    // taken, only the exact limits count as saturated, and no mass comes out.
    offer_poll(32'd100, 1'b1, 24'h7F_FFFF);
    offer_poll(32'd101, 1'b0, 24'h12_3456);
    offer_poll(32'd102, 1'b1, 24'h80_0000);

    // Small known scale with a negative tare and a 10 ms interval.
    wait_drained();
    load_setup(10, 100, 1, 420, 1, 24'hFF_FFFB, 1);
    offer_poll(32'd1000, 1'b1, 24'h00_0000);
    offer_poll(32'd1005, 1'b1, 24'h7F_FFFF);   // too soon after the last read
    offer_poll(32'd1010, 1'b1, 24'h7F_FFFF);   // exactly one interval later
    offer_poll(32'd1011, 1'b0, 24'hFF_FFFF);   // converter not ready
    offer_poll(32'd1020, 1'b1, 24'hFF_FFFF);
    offer_poll(32'd1030, 1'b1, 24'h00_0001);
    offer_poll(32'd1040, 1'b1, 24'h7F_FF9B);   // right on the upper margin
    offer_poll(32'd1050, 1'b1, 24'h7F_FF9A);   // one count inside it
    offer_poll(32'd1060, 1'b1, 24'h80_0064);   // right on the lower margin
    offer_poll(32'd1070, 1'b1, 24'h80_0065);
    offer_poll(32'd1080, 1'b1, 24'hFF_FFFB);   // reading equals the tare
    offer_poll(32'd1090, 1'b1, 24'hFF_FF00);   // negative quotient truncates up
    offer_poll(32'd0, 1'b1, 24'h00_0010);      // read at time zero
    offer_poll(32'd3, 1'b1, 24'h00_0020);      // so this one counts as a first read
    offer_poll(32'hFFFF_FFFF, 1'b1, 24'h40_0000);
    offer_poll(32'd5, 1'b1, 24'h3F_FFFF);      // elapsed across the wrap is 6
    offer_poll(32'd9, 1'b1, 24'hC0_0000);      // and now it is 10
    offer_poll(32'd9, 1'b1, 24'h55_AAAA);
    ms_clock = 32'd9;

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0: begin
          realistic_setup(1'b1, 1'b1, 1'b1, 1'b1);
          calm = 1'b1;   // one long stretch with neither side idling
        end
        1: load_setup(65535, 8388607, 1, 24'hFF_FFFF, 65535, 24'h80_0000, 1);
        2: realistic_setup(1'b1, 1'b1, 1'b1, 1'b1);
        3: realistic_setup(1'b0, 1'b1, 1'b1, 1'b1);
        4: realistic_setup(1'b1, 1'b0, 1'b1, 1'b1);
        5: realistic_setup(1'b1, 1'b1, 1'b0, 1'b1);
        6: realistic_setup(1'b1, 1'b1, 1'b1, 1'b0);
        default: load_setup($urandom_range(0, 50), $urandom_range(0, 8388607), 1,
                            $urandom_range(1, 7), 65535 - $urandom_range(0, 100),
                            $urandom(), 1);
      endcase
      for (int n = 0; n < PHASE_POLLS; n++) begin
        if (p == 2 && n == 40) hold_rx = 1'b1;     // receiver backs up, sender keeps going
        if (p == 2 && n == 120) wait_drained();    // sender pauses until all words are back
        offer_random_poll();
      end
      calm = 1'b0;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d polls across %0d register setups and compared %0d result words.",
             polls_sent, setups, compared);
    $display("%0d polls were taken as readings, %0d of them with a valid mass.",
             reads_taken, masses_valid);
    if (mismatches == 0 && backlog == 0) begin
      $display("load_cell_reading_scaler: match");
    end else begin
      $display("load_cell_reading_scaler: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/lcrs_pkg.sv
rtl/lcrs_muldiv.sv
rtl/load_cell_reading_scaler.sv
rtl/lcrs_checker.sv
verif/lcrs_reading_checker.sv
verif/tb.sv
